// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, used by triangle_tangent_frame_core
// clocked property checks that compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TTF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");
`define TTF_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("%m: forbidden condition");
`else
`define TTF_ASSERT(lbl, clk, rstn, prop)
`define TTF_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/ttf_pkg.sv =====
// shared widths, codes and types of the triangle tangent frame block
// no dependencies
package ttf_pkg;

    localparam int INDEX_BITS    = 16;
    localparam int POSITION_BITS = 24;
    localparam int TEX_BITS      = 20;
    localparam int UNIT_BITS     = 16;
    localparam int CORNERS       = 3;

    // datapath widths
    localparam int EDGE_W    = POSITION_BITS + 1;
    localparam int DT_W      = TEX_BITS + 1;
    localparam int VEC_W     = EDGE_W + DT_W + 2;
    localparam int NORM_BITS = 30;
    localparam int MUL_W     = (EDGE_W > NORM_BITS + 1) ? EDGE_W : NORM_BITS + 1;
    localparam int ACC_W     = 2 * MUL_W + 2;
    localparam int SQ_W      = 2 * NORM_BITS + 2;
    localparam int ROOT_W    = NORM_BITS + 1;
    localparam int DIVD_W    = NORM_BITS + UNIT_BITS + 1;
    localparam int DIVS_W    = ROOT_W + 1;
    localparam int QUOT_W    = UNIT_BITS;
    localparam int UNIT_MAX  = 2 ** (UNIT_BITS - 1) - 1;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // stream packing
    localparam int IN_BITS    = INDEX_BITS + 3 * POSITION_BITS + 2 * TEX_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = INDEX_BITS + 6 * UNIT_BITS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OFS_PX     = INDEX_BITS;
    localparam int OFS_PY     = OFS_PX + POSITION_BITS;
    localparam int OFS_PZ     = OFS_PY + POSITION_BITS;
    localparam int OFS_U      = OFS_PZ + POSITION_BITS;
    localparam int OFS_V      = OFS_U + TEX_BITS;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } ttf_op_e;

    typedef enum logic [2:0] {
        DST_DET,
        DST_A0,
        DST_A1,
        DST_A2,
        DST_B0,
        DST_B1,
        DST_B2,
        DST_SUM
    } ttf_dst_e;

    typedef struct packed {
        logic     vld;
        logic     load;
        logic     neg;
        logic     store;
        ttf_dst_e dst;
    } ttf_mac_tag_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_DET,
        E_TB,
        E_SIGN,
        E_MAG,
        E_SHIFT,
        E_SQ,
        E_SQRT_GO,
        E_SQRT_WAIT,
        E_DIV_GO,
        E_DIV_WAIT,
        E_CROSS,
        E_DONE
    } ttf_eng_state_e;

    typedef enum logic [1:0] {
        T_COLLECT,
        T_WORK,
        T_SEND
    } ttf_top_state_e;

    typedef struct packed {
        logic [2:0][EDGE_W-1:0] e1;
        logic [2:0][EDGE_W-1:0] e2;
        logic [DT_W-1:0]        du1;
        logic [DT_W-1:0]        dv1;
        logic [DT_W-1:0]        du2;
        logic [DT_W-1:0]        dv2;
    } ttf_geom_t;

    typedef struct packed {
        logic done;
        logic ok;
    } ttf_eng_stat_t;

    typedef struct packed {
        logic    start;
        ttf_op_e op;
    } ttf_rd_ctl_t;

    function automatic ttf_dst_e dst_a(input logic [1:0] i);
        case (i)
            2'd0:    return DST_A0;
            2'd1:    return DST_A1;
            default: return DST_A2;
        endcase
    endfunction

    function automatic ttf_dst_e dst_b(input logic [1:0] i);
        case (i)
            2'd0:    return DST_B0;
            2'd1:    return DST_B1;
            default: return DST_B2;
        endcase
    endfunction

    // (i + k) mod 3 for a component index
    function automatic logic [1:0] idx_add(input logic [1:0] i, input logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, i} + {1'b0, k};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

endpackage

// ===== rtl/ttf_rootdiv.sv =====
// shared shift-subtract unit: integer square root or restoring division
// depends on ttf_pkg
module ttf_rootdiv
    import ttf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ttf_rd_ctl_t          ctl,
    input  logic [SQ_W-1:0]      radicand,
    input  logic [DIVD_W-1:0]    dividend,
    input  logic [DIVS_W-1:0]    divisor,
    output logic                 done,
    output logic [ROOT_W-1:0]    root,
    output logic [QUOT_W-1:0]    quot
);

    ttf_op_e           op_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [SQ_W-1:0]   r_reg;
    logic [SQ_W-1:0]   b_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [SQ_W:0]     add_w;
    logic              ge;

    // one trial subtract per cycle
    always_comb begin
        add_w = {1'b0, r_reg} + ((op_reg == OP_SQRT) ? {1'b0, b_reg} : '0);
        ge    = ({1'b0, x_reg} >= add_w);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (ctl.start) begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= (ctl.op == OP_SQRT) ? STEP_W'(SQRT_STEPS - 1)
                                                : STEP_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            x_reg <= (ctl.op == OP_SQRT) ? radicand : SQ_W'(dividend);
            r_reg <= (ctl.op == OP_SQRT) ? '0 : (SQ_W'(divisor) << (DIV_STEPS - 1));
            b_reg <= SQ_W'(1) << (SQ_W - 2);
            q_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                x_reg <= x_reg - add_w[SQ_W-1:0];
            end
            if (op_reg == OP_SQRT && ge) begin
                r_reg <= (r_reg >> 1) + b_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
            q_reg <= {q_reg[QUOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];
    assign quot = q_reg;

endmodule

// ===== rtl/ttf_engine.sv =====
// sequencer and shared multiply-accumulate for the tangent frame math
// depends on ttf_pkg and ttf_rootdiv
module ttf_engine
    import ttf_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  ttf_geom_t                     geom,
    output ttf_eng_stat_t                 stat,
    output logic [2:0][UNIT_BITS-1:0]     tangent,
    output logic [2:0][UNIT_BITS-1:0]     normal
);

    ttf_eng_state_e state_reg, state_next;
    logic [3:0]     cnt_reg;
    logic [1:0]     comp_reg;
    logic [1:0]     nsel_reg;
    logic           ok_reg;
    logic           done_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;
    ttf_mac_tag_t              issue, tag_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, prod_ext;

    logic signed [VEC_W-1:0]   det_reg;
    logic signed [VEC_W-1:0]   va_reg [3];
    logic signed [VEC_W-1:0]   vb_reg [3];
    logic [VEC_W-1:0]          mag_reg [3];
    logic                      sgn_reg [3];
    logic [SQ_W-1:0]           sum_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic signed [UNIT_BITS-1:0] tu_reg [3];
    logic signed [UNIT_BITS-1:0] bu_reg [3];
    logic signed [UNIT_BITS-1:0] nu_reg [3];

    logic signed [VEC_W-1:0]   src [3];
    logic                      src_zero;
    logic [VEC_W-1:0]          mag_or;
    logic                      mag_hi, mag_ok;
    logic                      unit_done;
    logic [1:0]                ci, cj1, cj2;

    ttf_rd_ctl_t               rd_ctl;
    logic                      rd_done;
    logic [ROOT_W-1:0]         rd_root;
    logic [QUOT_W-1:0]         rd_quot;
    logic [DIVD_W-1:0]         rd_dividend;
    logic [UNIT_BITS-1:0]      q_sat, q_signed;

    ttf_rootdiv u_rootdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rd_ctl),
        .radicand (sum_reg),
        .dividend (rd_dividend),
        .divisor  ({root_reg, 1'b0}),
        .done     (rd_done),
        .root     (rd_root),
        .quot     (rd_quot)
    );

    // vector under normalization and shift-window checks
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            src[i] = (nsel_reg == 2'd1) ? vb_reg[i] : va_reg[i];
        end
        src_zero = (src[0] == '0) && (src[1] == '0) && (src[2] == '0);
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        mag_hi   = |mag_or[VEC_W-1:NORM_BITS];
        mag_ok   = !mag_hi && mag_or[NORM_BITS-1];
        unit_done = (state_reg == E_MAG && src_zero) ||
                    (state_reg == E_DIV_WAIT && rd_done && comp_reg == 2'd2);
    end

    // rounded quotient, saturated and signed
    always_comb begin
        rd_dividend = DIVD_W'({mag_reg[comp_reg][NORM_BITS-1:0], UNIT_BITS'(0)})
                      + DIVD_W'(root_reg);
        q_sat    = (rd_quot > QUOT_W'(UNIT_MAX)) ? UNIT_BITS'(UNIT_MAX) : rd_quot;
        q_signed = sgn_reg[comp_reg] ? (UNIT_BITS'(0) - q_sat) : q_sat;
        rd_ctl.start = (state_reg == E_SQRT_GO) || (state_reg == E_DIV_GO);
        rd_ctl.op    = (state_reg == E_DIV_GO) ? OP_DIV : OP_SQRT;
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        issue     = '0;
        issue.dst = DST_DET;
        ci  = cnt_reg[3:2];
        cj1 = idx_add(cnt_reg[2:1], 2'd1);
        cj2 = idx_add(cnt_reg[2:1], 2'd2);
        case (state_reg)
            E_DET: begin
                if (cnt_reg < 4'd2) begin
                    issue.vld = 1'b1;
                    if (cnt_reg == 4'd0) begin
                        mul_a      = MUL_W'($signed(geom.du1));
                        mul_b      = MUL_W'($signed(geom.dv2));
                        issue.load = 1'b1;
                    end else begin
                        mul_a       = MUL_W'($signed(geom.dv1));
                        mul_b       = MUL_W'($signed(geom.du2));
                        issue.neg   = 1'b1;
                        issue.store = 1'b1;
                    end
                end
            end
            E_TB: begin
                if (cnt_reg < 4'd12) begin
                    issue.vld = 1'b1;
                    case (cnt_reg[1:0])
                        2'd0: begin
                            mul_a      = MUL_W'($signed(geom.dv2));
                            mul_b      = MUL_W'($signed(geom.e1[ci]));
                            issue.load = 1'b1;
                        end
                        2'd1: begin
                            mul_a       = MUL_W'($signed(geom.dv1));
                            mul_b       = MUL_W'($signed(geom.e2[ci]));
                            issue.neg   = 1'b1;
                            issue.store = 1'b1;
                            issue.dst   = dst_a(ci);
                        end
                        2'd2: begin
                            mul_a      = MUL_W'($signed(geom.du1));
                            mul_b      = MUL_W'($signed(geom.e2[ci]));
                            issue.load = 1'b1;
                        end
                        default: begin
                            mul_a       = MUL_W'($signed(geom.du2));
                            mul_b       = MUL_W'($signed(geom.e1[ci]));
                            issue.neg   = 1'b1;
                            issue.store = 1'b1;
                            issue.dst   = dst_b(ci);
                        end
                    endcase
                end
            end
            E_SQ: begin
                if (cnt_reg < 4'd3) begin
                    issue.vld   = 1'b1;
                    mul_a       = MUL_W'($signed({1'b0, mag_reg[cnt_reg[1:0]][NORM_BITS-1:0]}));
                    mul_b       = mul_a;
                    issue.load  = (cnt_reg == 4'd0);
                    issue.store = (cnt_reg == 4'd2);
                    issue.dst   = DST_SUM;
                end
            end
            E_CROSS: begin
                if (cnt_reg < 4'd6) begin
                    issue.vld = 1'b1;
                    if (!cnt_reg[0]) begin
                        mul_a      = MUL_W'(tu_reg[cj1]);
                        mul_b      = MUL_W'(bu_reg[cj2]);
                        issue.load = 1'b1;
                    end else begin
                        mul_a       = MUL_W'(tu_reg[cj2]);
                        mul_b       = MUL_W'(bu_reg[cj1]);
                        issue.neg   = 1'b1;
                        issue.store = 1'b1;
                        issue.dst   = dst_a(cnt_reg[2:1]);
                    end
                end
            end
            default: begin
                issue.vld = 1'b0;
            end
        endcase
    end

    // accumulate the registered product
    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        acc_next = (tag_reg.load ? '0 : acc_reg) + (tag_reg.neg ? -prod_ext : prod_ext);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE:      if (start) state_next = E_DET;
            E_DET:       if (cnt_reg == 4'd2) state_next = E_TB;
            E_TB:        if (cnt_reg == 4'd12) state_next = E_SIGN;
            E_SIGN:      state_next = E_MAG;
            E_MAG:       if (!src_zero) state_next = E_SHIFT;
            E_SHIFT:     if (mag_ok) state_next = E_SQ;
            E_SQ:        if (cnt_reg == 4'd3) state_next = E_SQRT_GO;
            E_SQRT_GO:   state_next = E_SQRT_WAIT;
            E_SQRT_WAIT: if (rd_done) state_next = E_DIV_GO;
            E_DIV_GO:    state_next = E_DIV_WAIT;
            E_DIV_WAIT:  if (rd_done) state_next = E_DIV_GO;
            E_CROSS:     if (cnt_reg == 4'd6) state_next = E_MAG;
            E_DONE:      state_next = E_IDLE;
            default:     state_next = E_IDLE;
        endcase
        // a finished unit vector moves on to the next one, or to E_DONE after the third
        if (unit_done) begin
            case (nsel_reg)
                2'd0:    state_next = E_MAG;
                2'd1:    state_next = E_CROSS;
                default: state_next = E_DONE;
            endcase
        end
    end

    // state and sequencing counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            nsel_reg  <= '0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
            tag_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? 4'd0 : cnt_reg + 4'd1;
            tag_reg   <= issue;
            done_reg  <= (state_reg == E_DONE);
            if (state_reg == E_IDLE && start) begin
                nsel_reg <= '0;
                ok_reg   <= 1'b1;
            end
            if (state_reg == E_SIGN && det_reg == '0) begin
                ok_reg <= 1'b0;
            end
            if (state_reg == E_MAG && src_zero) begin
                ok_reg <= 1'b0;
            end
            if (unit_done) begin
                nsel_reg <= nsel_reg + 2'd1;
            end
            if (state_reg == E_SQRT_WAIT) begin
                comp_reg <= '0;
            end else if (state_reg == E_DIV_WAIT && rd_done) begin
                comp_reg <= comp_reg + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (tag_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (tag_reg.vld && tag_reg.store) begin
            case (tag_reg.dst)
                DST_DET: det_reg   <= acc_next[VEC_W-1:0];
                DST_A0:  va_reg[0] <= acc_next[VEC_W-1:0];
                DST_A1:  va_reg[1] <= acc_next[VEC_W-1:0];
                DST_A2:  va_reg[2] <= acc_next[VEC_W-1:0];
                DST_B0:  vb_reg[0] <= acc_next[VEC_W-1:0];
                DST_B1:  vb_reg[1] <= acc_next[VEC_W-1:0];
                DST_B2:  vb_reg[2] <= acc_next[VEC_W-1:0];
                default: sum_reg   <= acc_next[SQ_W-1:0];
            endcase
        end
        // a negative determinant flips both directions
        if (state_reg == E_SIGN && det_reg[VEC_W-1]) begin
            for (int i = 0; i < 3; i++) begin
                va_reg[i] <= -va_reg[i];
                vb_reg[i] <= -vb_reg[i];
            end
        end
        // magnitudes and signs
        if (state_reg == E_MAG) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= src[i][VEC_W-1] ? VEC_W'(-src[i]) : VEC_W'(src[i]);
                sgn_reg[i] <= src[i][VEC_W-1];
            end
        end
        // shift all three until the largest sits in the window
        if (state_reg == E_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                if (mag_hi) begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end else if (!mag_or[NORM_BITS-1]) begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
            end
        end
        if (state_reg == E_SQRT_WAIT && rd_done) begin
            root_reg <= rd_root;
        end
        // zero vector gives zero components
        if (state_reg == E_MAG && src_zero) begin
            for (int i = 0; i < 3; i++) begin
                case (nsel_reg)
                    2'd0:    tu_reg[i] <= '0;
                    2'd1:    bu_reg[i] <= '0;
                    default: nu_reg[i] <= '0;
                endcase
            end
        end
        if (state_reg == E_DIV_WAIT && rd_done) begin
            case (nsel_reg)
                2'd0:    tu_reg[comp_reg] <= q_signed;
                2'd1:    bu_reg[comp_reg] <= q_signed;
                default: nu_reg[comp_reg] <= q_signed;
            endcase
        end
    end

    // results, zeroed when the frame is degenerate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tangent[i] = ok_reg ? tu_reg[i] : '0;
            normal[i]  = ok_reg ? nu_reg[i] : '0;
        end
        stat.done = done_reg;
        stat.ok   = ok_reg;
    end

endmodule

// ===== rtl/triangle_tangent_frame_core.sv =====
// Triangle tangent frame core. Corners stream in one item at a time; the first two
// are held and taken with no wait. The third starts the frame computation: the
// texture determinant and the raw tangent and bitangent take 14 multiply steps,
// then each of the three unit vectors (tangent, bitangent, tangent cross
// bitangent with 6 more multiply steps) is shifted into the normalization
// window, squared and summed, square-rooted and divided per component with
// rounding, all through one multiplier and one shift-subtract unit. A zero
// vector skips the shift, root and divide steps. A triangle's three result
// items, one per corner in arrival order, are then offered; no new corner
// is taken until the third result item is delivered.
// fill_zero_normals is written through cfg_we/cfg_wdata and resets to 1.
`include "assert_macros.svh"
module triangle_tangent_frame_core
    import ttf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,     // fill_zero_normals
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // vertex_id, pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,       // normal_is_zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_vertex_id, tangent_x, tangent_y, tangent_z, normal_x, normal_y, normal_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,       // write_normal, degenerate
    output logic                  m_tlast        // last_of_triangle
);

    ttf_top_state_e state_reg, state_next;
    logic [1:0]     corner_reg;
    logic [1:0]     out_cnt_reg;
    logic           fill_reg;
    logic           start_reg;
    logic           in_acc, out_acc;

    logic signed [POSITION_BITS-1:0] pos_in [3];
    logic signed [TEX_BITS-1:0]      u_in, v_in;
    logic signed [POSITION_BITS-1:0] p0_reg [3];
    logic signed [POSITION_BITS-1:0] p1_reg [3];
    logic signed [TEX_BITS-1:0]      u0_reg, v0_reg, u1_reg, v1_reg;
    logic [INDEX_BITS-1:0]           id_reg [3];
    logic                            nz_reg [3];
    ttf_geom_t                       geom_reg;

    ttf_eng_stat_t                   eng_stat;
    logic [2:0][UNIT_BITS-1:0]       eng_t, eng_n;
    logic                            wn;

    ttf_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .geom    (geom_reg),
        .stat    (eng_stat),
        .tangent (eng_t),
        .normal  (eng_n)
    );

    // field unpacking and handshakes
    always_comb begin
        pos_in[0] = s_tdata[OFS_PX +: POSITION_BITS];
        pos_in[1] = s_tdata[OFS_PY +: POSITION_BITS];
        pos_in[2] = s_tdata[OFS_PZ +: POSITION_BITS];
        u_in      = s_tdata[OFS_U +: TEX_BITS];
        v_in      = s_tdata[OFS_V +: TEX_BITS];
        in_acc    = s_tvalid && s_tready;
        out_acc   = m_tvalid && m_tready;
    end

    // next state and outputs
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_COLLECT: if (in_acc && corner_reg == 2'd2) state_next = T_WORK;
            T_WORK:    if (eng_stat.done) state_next = T_SEND;
            T_SEND:    if (out_acc && out_cnt_reg == 2'd2) state_next = T_COLLECT;
            default:   state_next = T_COLLECT;
        endcase
        s_tready = (state_reg == T_COLLECT);
        m_tvalid = (state_reg == T_SEND);
        wn       = fill_reg && nz_reg[out_cnt_reg];
        m_tdata  = OUT_DATA_W'({wn ? eng_n[2] : UNIT_BITS'(0),
                                wn ? eng_n[1] : UNIT_BITS'(0),
                                wn ? eng_n[0] : UNIT_BITS'(0),
                                eng_t[2], eng_t[1], eng_t[0],
                                id_reg[out_cnt_reg]});
        m_tuser  = {!eng_stat.ok, wn};
        m_tlast  = (out_cnt_reg == 2'd2);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_COLLECT;
            corner_reg  <= '0;
            out_cnt_reg <= '0;
            fill_reg    <= 1'b1;
            start_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= in_acc && (corner_reg == 2'd2);
            if (cfg_we) begin
                fill_reg <= cfg_wdata;
            end
            if (in_acc) begin
                corner_reg <= (corner_reg == 2'd2) ? 2'd0 : corner_reg + 2'd1;
            end
            if (out_acc) begin
                out_cnt_reg <= (out_cnt_reg == 2'd2) ? 2'd0 : out_cnt_reg + 2'd1;
            end
        end
    end

    // corner holding and edge deltas
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            id_reg[corner_reg] <= s_tdata[INDEX_BITS-1:0];
            nz_reg[corner_reg] <= s_tuser;
            case (corner_reg)
                2'd0: begin
                    for (int i = 0; i < 3; i++) p0_reg[i] <= pos_in[i];
                    u0_reg <= u_in;
                    v0_reg <= v_in;
                end
                2'd1: begin
                    for (int i = 0; i < 3; i++) p1_reg[i] <= pos_in[i];
                    u1_reg <= u_in;
                    v1_reg <= v_in;
                end
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        geom_reg.e1[i] <= EDGE_W'(p1_reg[i]) - EDGE_W'(p0_reg[i]);
                        geom_reg.e2[i] <= EDGE_W'(pos_in[i]) - EDGE_W'(p0_reg[i]);
                    end
                    geom_reg.du1 <= DT_W'(u1_reg) - DT_W'(u0_reg);
                    geom_reg.dv1 <= DT_W'(v1_reg) - DT_W'(v0_reg);
                    geom_reg.du2 <= DT_W'(u_in) - DT_W'(u0_reg);
                    geom_reg.dv2 <= DT_W'(v_in) - DT_W'(v0_reg);
                end
            endcase
        end
    end

    // checks
    `TTF_NEVER(a_no_in_while_out, aclk, aresetn, m_tvalid && s_tready)
    `TTF_ASSERT(a_last_restarts, aclk, aresetn, (out_acc && m_tlast) |=> (s_tready && corner_reg == 2'd0))
    `TTF_ASSERT(a_degen_zero, aclk, aresetn, (m_tvalid && m_tuser[1]) |-> (m_tdata[OUT_DATA_W-1:INDEX_BITS] == '0))
    `TTF_ASSERT(a_start_once, aclk, aresetn, start_reg |-> (state_reg == T_WORK))

endmodule
